// ===== rtl/tpsb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the TMDS palette symbol builder.
// No dependencies; every rtl file refers to it by scoped names.
package tpsb_pkg;

    localparam int INDEX_W = 8;
    localparam int RGB_W   = 24;
    localparam int CHAN_W  = 8;
    localparam int SYM_W   = 10;
    localparam int WORD_W  = 62;
    localparam int GRP_W   = 6;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 136;

    localparam logic [WORD_W-1:0]  ODD_MASK    = 62'h0003_ffff_ffff_ffff;
    localparam logic [INDEX_W-1:0] RESERVED_LO = 8'd250;
    localparam logic [INDEX_W-1:0] RESERVED_HI = 8'd254;
    localparam logic [1:0]         PAIR_FLIP   = 2'b11;

    typedef enum logic [0:0] {
        REG_INVERT_PAIRS     = 1'b0,
        REG_RED_ON_HIGH_PINS = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic invert_pairs;
        logic red_on_high_pins;
    } pin_cfg_t;

endpackage

// ===== rtl/tpsb_tmds_enc.sv =====
`timescale 1ns / 1ps
// Transition-minimizing TMDS encoder for one 8-bit channel, no DC balance.
// Depends on tpsb_pkg for widths.
module tpsb_tmds_enc (
    input  logic [tpsb_pkg::CHAN_W-1:0] chan_byte,
    output logic [tpsb_pkg::SYM_W-1:0]  symbol
);

    logic [3:0]                  ones;
    logic                        use_xnor;
    logic [tpsb_pkg::CHAN_W-1:0] q;

    always_comb begin
        ones = '0;
        for (int i = 0; i < tpsb_pkg::CHAN_W; i++) begin
            ones = ones + {3'b000, chan_byte[i]};
        end
        use_xnor = (ones > 4'd4) || (ones == 4'd4 && !chan_byte[0]);

        // bit 0 passes through, the rest chain on the previous output bit
        q[0] = chan_byte[0];
        for (int i = 1; i < tpsb_pkg::CHAN_W; i++) begin
            q[i] = q[i-1] ^ chan_byte[i] ^ use_xnor;
        end

        symbol = {use_xnor, ~use_xnor, q};
    end

endmodule

// ===== rtl/tpsb_pin_packer.sv =====
`timescale 1ns / 1ps
// Serializes three TMDS symbols, bit 0 first, into 6-bit differential pin groups.
// Depends on tpsb_pkg for widths, masks and the pin configuration struct.
module tpsb_pin_packer (
    input  tpsb_pkg::pin_cfg_t          pin_cfg,
    input  logic [tpsb_pkg::SYM_W-1:0]  sym_red,
    input  logic [tpsb_pkg::SYM_W-1:0]  sym_green,
    input  logic [tpsb_pkg::SYM_W-1:0]  sym_blue,
    output logic [tpsb_pkg::WORD_W-1:0] even_word,
    output logic [tpsb_pkg::WORD_W-1:0] odd_word
);

    logic [1:0] flip;

    assign flip = pin_cfg.invert_pairs ? tpsb_pkg::PAIR_FLIP : 2'b00;

    always_comb begin
        logic [1:0]              pr, pg, pb;
        logic [tpsb_pkg::GRP_W-1:0] grp;
        even_word = '0;
        for (int k = 0; k < tpsb_pkg::SYM_W; k++) begin
            pr = {~sym_red[k],   sym_red[k]}   ^ flip;
            pg = {~sym_green[k], sym_green[k]} ^ flip;
            pb = {~sym_blue[k],  sym_blue[k]}  ^ flip;
            grp = pin_cfg.red_on_high_pins ? {pr, pg, pb} : {pb, pg, pr};
            // low five bits fill 0-29, high five start at bit 32
            if (k < 5) begin
                even_word[6*k +: tpsb_pkg::GRP_W] = grp;
            end else begin
                even_word[32 + 6*(k-5) +: tpsb_pkg::GRP_W] = grp;
            end
        end
        odd_word = even_word ^ tpsb_pkg::ODD_MASK;
    end

endmodule

// ===== rtl/tmds_palette_symbol_builder.sv =====
`timescale 1ns / 1ps
// Top level: input register, TMDS encode and pin packing, result register.
// Depends on tpsb_pkg, tpsb_tmds_enc and tpsb_pin_packer.
//
//  channel   direction  beat contents (low bits first)
//  s_*       in         entry_index[7:0], color_rgb[31:8]
//  m_*       out        table_slot[7:0], even_word[69:8], odd_word[131:70], zero pad
//  cfg_*     in         cfg_addr selects register, cfg_wdata[0] is the value
//
// One beat per cycle sustained while m_tready stays high; each beat is captured in the
// input register, then encoded and packed into the result register.
// aresetn is synchronous, active low; it empties both stages and restores
// invert_pairs = 0, red_on_high_pins = 1.
// Entries 250 to 254 are accepted and dropped in the input stage.
// m_tready low holds the result; the input stage still fills behind it.
module tmds_palette_symbol_builder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tpsb_pkg::S_TDATA_W-1:0]   s_tdata,  // entry_index, color_rgb
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tpsb_pkg::M_TDATA_W-1:0]   m_tdata,  // table_slot, even_word, odd_word, pad
    input  logic                             cfg_wr_en,
    input  logic [0:0]                       cfg_addr,
    input  logic [0:0]                       cfg_wdata
);

    tpsb_pkg::pin_cfg_t                cfg_reg;
    logic                              stage_valid_reg;
    logic [tpsb_pkg::INDEX_W-1:0]      stage_index_reg;
    logic [tpsb_pkg::RGB_W-1:0]        stage_rgb_reg;
    logic                              out_valid_reg;
    logic [tpsb_pkg::INDEX_W-1:0]      out_slot_reg;
    logic [tpsb_pkg::WORD_W-1:0]       out_even_reg;
    logic [tpsb_pkg::WORD_W-1:0]       out_odd_reg;

    logic                              out_load;
    logic                              s_beat;
    logic                              in_reserved;
    logic [tpsb_pkg::SYM_W-1:0]        sym_red, sym_green, sym_blue;
    logic [tpsb_pkg::WORD_W-1:0]       even_next, odd_next;

    assign out_load    = !out_valid_reg || m_tready;
    assign s_tready    = !stage_valid_reg || out_load;
    assign s_beat      = s_tvalid && s_tready;
    assign in_reserved = (s_tdata[7:0] >= tpsb_pkg::RESERVED_LO)
                      && (s_tdata[7:0] <= tpsb_pkg::RESERVED_HI);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.invert_pairs     <= 1'b0;
            cfg_reg.red_on_high_pins <= 1'b1;
        end else if (cfg_wr_en) begin
            case (tpsb_pkg::reg_index_t'(cfg_addr))
                tpsb_pkg::REG_INVERT_PAIRS:     cfg_reg.invert_pairs     <= cfg_wdata[0];
                tpsb_pkg::REG_RED_ON_HIGH_PINS: cfg_reg.red_on_high_pins <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input stage: drop reserved entries here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_tready) begin
            stage_valid_reg <= s_tvalid && !in_reserved;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            stage_index_reg <= s_tdata[7:0];
            stage_rgb_reg   <= s_tdata[31:8];
        end
    end

    tpsb_tmds_enc u_enc_red (
        .chan_byte (stage_rgb_reg[23:16]),
        .symbol    (sym_red)
    );

    tpsb_tmds_enc u_enc_green (
        .chan_byte (stage_rgb_reg[15:8]),
        .symbol    (sym_green)
    );

    tpsb_tmds_enc u_enc_blue (
        .chan_byte (stage_rgb_reg[7:0]),
        .symbol    (sym_blue)
    );

    tpsb_pin_packer u_packer (
        .pin_cfg   (cfg_reg),
        .sym_red   (sym_red),
        .sym_green (sym_green),
        .sym_blue  (sym_blue),
        .even_word (even_next),
        .odd_word  (odd_next)
    );

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && stage_valid_reg) begin
            out_slot_reg <= stage_index_reg;
            out_even_reg <= even_next;
            out_odd_reg  <= odd_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_odd_reg, out_even_reg, out_slot_reg};

`ifndef SYNTHESIS
    a_no_reserved_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !((out_slot_reg >= tpsb_pkg::RESERVED_LO)
                    && (out_slot_reg <= tpsb_pkg::RESERVED_HI)))
        else $error("reserved entry reached the result register");

    a_odd_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((out_odd_reg ^ out_even_reg) == tpsb_pkg::ODD_MASK))
        else $error("odd word does not match even word under mask");

    a_gap_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_even_reg[31:30] == 2'b00))
        else $error("gap bits of even word are set");

    a_reserved_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && in_reserved) |=> !stage_valid_reg)
        else $error("reserved entry entered the input stage");

    a_stage_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid_reg && out_load) |=> m_tvalid)
        else $error("input stage item lost on advance");
`endif

endmodule
